### rtl/core/bph_pkg.sv
package bph_pkg;

    // Fixed widths of the stream fields.
    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int COUNT_W    = 16;

    // Operation codes carried on the slave-side tuser.
    localparam logic [OP_W-1:0] OP_FEED  = 2'd0;
    localparam logic [OP_W-1:0] OP_FETCH = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // One result item as it leaves the controller for the output register.
    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] pair_count;
        logic [CHAR_W-1:0]  second_char;
        logic [CHAR_W-1:0]  first_char;
    } bph_result_t;

endpackage

### rtl/core/byte_pair_histogram.sv
// Byte pair histogram: counts adjacent byte pairs of a string and reports the
// distinct pairs with their counts in ascending pair order.
// Input channel s_axis: tuser carries the operation (feed, fetch, clear) and
// tdata the byte for a feed. Output channel m_axis: one item per fetch, with
// tdata holding first byte, second byte and count, and tuser the found flag.
// Counts live in one synchronous RAM of 2^(2*CHAR_BITS) words; each feed reads
// the counter of the pair, increments it with saturation and writes it back.
// A feed with a previous byte held reads the counter, then writes it back;
// otherwise it touches no RAM. A fetch reads on from the scan position, one
// RAM read per cycle while it skips empty entries, and loads the first nonempty
// entry, or a not-found item at the end of the table, into the output register.
// A clear writes zeros to all 2^(2*CHAR_BITS) words (65536 at the default),
// with s_axis_tready low throughout. Reset starts the same clearing pass, so
// the block accepts its first item only once the table is clear. A finished
// result sits in an output register; feeds and clears are still accepted
// while it waits, and a further fetch stalls only at its final step until
// the receiver takes the earlier result.
module byte_pair_histogram #(
    parameter int CHAR_BITS   = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // character[7:0]
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // first_char[7:0], second_char[15:8],
                                        // pair_count[31:16]
    output logic [0:0]  m_axis_tuser    // found[0]
);

    import bph_pkg::*;

    localparam int ADDR_W     = 2 * CHAR_BITS;
    localparam int POS_W      = ADDR_W + 1;
    localparam int TABLE_SIZE = 1 << ADDR_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FEED_WR,
        ST_SCAN,
        ST_EMIT_NF,
        ST_CLEAR
    } state_t;

    state_t                 state_reg, state_next;
    logic [CHAR_BITS-1:0]   prev_reg, prev_next;
    logic                   have_prev_reg, have_prev_next;
    logic [POS_W-1:0]       scan_reg, scan_next;
    logic [ADDR_W-1:0]      idx_reg, idx_next;
    logic [ADDR_W-1:0]      clr_reg, clr_next;

    logic                   ram_wr_en;
    logic [ADDR_W-1:0]      ram_wr_addr;
    logic [COUNT_WIDTH-1:0] ram_wr_data;
    logic                   ram_rd_en;
    logic [ADDR_W-1:0]      ram_rd_addr;
    logic [COUNT_WIDTH-1:0] ram_rd_data;

    logic                   out_load;
    logic                   out_free;
    bph_result_t            out_result;

    logic                   in_accept;
    logic [CHAR_BITS-1:0]   in_char;
    logic [POS_W-1:0]       scan_inc;
    logic [CHAR_BITS-1:0]   pos_hi;
    logic [CHAR_BITS-1:0]   pos_lo;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_char       = s_axis_tdata[CHAR_BITS-1:0];
    assign scan_inc      = scan_reg + POS_W'(1);
    assign pos_hi        = scan_reg[ADDR_W-1:CHAR_BITS];
    assign pos_lo        = scan_reg[CHAR_BITS-1:0];

    bph_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (TABLE_SIZE)
    ) u_counts (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    bph_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (out_load),
        .result        (out_result),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always_comb
    begin
        state_next     = state_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        scan_next      = scan_reg;
        idx_next       = idx_reg;
        clr_next       = clr_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = idx_reg;
        ram_wr_data    = '0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = scan_reg[ADDR_W-1:0];
        out_load       = 1'b0;
        out_result     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (s_axis_tuser)
                        OP_FEED:
                        begin
                            // Read the counter of (previous, current) when a
                            // previous byte exists; the write follows next cycle.
                            if (have_prev_reg)
                            begin
                                idx_next    = {prev_reg, in_char};
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = {prev_reg, in_char};
                                state_next  = ST_FEED_WR;
                            end
                            prev_next      = in_char;
                            have_prev_next = 1'b1;
                        end
                        OP_FETCH:
                        begin
                            if (scan_reg[ADDR_W])
                            begin
                                state_next = ST_EMIT_NF;
                            end
                            else
                            begin
                                ram_rd_en  = 1'b1;
                                state_next = ST_SCAN;
                            end
                        end
                        OP_CLEAR:
                        begin
                            prev_next      = '0;
                            have_prev_next = 1'b0;
                            scan_next      = '0;
                            clr_next       = '0;
                            state_next     = ST_CLEAR;
                        end
                        default:
                        begin
                            // The unused code changes nothing.
                        end
                    endcase
                end
            end
            ST_FEED_WR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_reg;
                if (ram_rd_data == {COUNT_WIDTH{1'b1}})
                begin
                    ram_wr_data = ram_rd_data;
                end
                else
                begin
                    ram_wr_data = ram_rd_data + COUNT_WIDTH'(1);
                end
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                // The read data belongs to the entry at scan_reg.
                if (ram_rd_data != '0)
                begin
                    if (out_free)
                    begin
                        out_load               = 1'b1;
                        out_result.found       = 1'b1;
                        out_result.first_char  = CHAR_W'(pos_hi);
                        out_result.second_char = CHAR_W'(pos_lo);
                        out_result.pair_count  = COUNT_W'(ram_rd_data);
                        scan_next              = scan_inc;
                        state_next             = ST_IDLE;
                    end
                end
                else
                begin
                    scan_next = scan_inc;
                    if (scan_inc[ADDR_W])
                    begin
                        state_next = ST_EMIT_NF;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = scan_inc[ADDR_W-1:0];
                    end
                end
            end
            ST_EMIT_NF:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_reg;
                ram_wr_data = '0;
                clr_next    = clr_reg + ADDR_W'(1);
                if (clr_reg == {ADDR_W{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            scan_reg      <= '0;
            idx_reg       <= '0;
            clr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            scan_reg      <= scan_next;
            idx_reg       <= idx_next;
            clr_reg       <= clr_next;
        end
    end

    // The RAM is never read and written in the same cycle.
    a_ram_single_access: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> !ram_rd_en)
        else $error("counter RAM read and written in one cycle");

    // The scan position never passes the end of the table.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg <= POS_W'(TABLE_SIZE))
        else $error("scan position beyond table");

    // A feed with a held previous byte is followed by its write-back.
    a_feed_writeback: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_axis_tuser == OP_FEED && have_prev_reg) |=> ram_wr_en)
        else $error("feed without counter write-back");

    // A result is loaded only into a free output register.
    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result overwrites a waiting item");

endmodule

### rtl/core/bph_ram.sv
module bph_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read data is registered and holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/bph_out_stage.sv
module bph_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  bph_pkg::bph_result_t result,
    output logic                free,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [31:0]         m_axis_tdata,
    output logic [0:0]          m_axis_tuser
);

    import bph_pkg::*;

    logic        valid_reg;
    bph_result_t data_reg;

    // The register is free when empty or when its item leaves this cycle.
    assign free = !valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            data_reg  <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                data_reg  <= result;
            end
            else if (m_axis_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {data_reg.pair_count, data_reg.second_char, data_reg.first_char};
    assign m_axis_tuser  = data_reg.found;

endmodule

### tb/sv/tb_top.sv
module tb_top;

    import bph_pkg::*;

    // The fourth operation code has no name in the package; the block ignores it.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // One counter for every ordered pair of characters.
    localparam int TABLE_SIZE = 1 << (2 * CHAR_W);
    localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

    // A clear, the clearing pass after reset, or a fetch that walks an empty
    // table each keep both channels quiet while the whole table is passed, so
    // the watchdog allows several times the table size before it gives up.
    localparam int WATCHDOG_LIMIT = 300000;
    // The long hold-off of the receiver in the back-pressure test.
    localparam int HOLD_CYCLES = 600;
    // Cycles allowed after the last result before the run is closed.
    localparam int TAIL_CYCLES = 50;
    // Random items per idling mode; together with the directed and
    // back-pressure items this comes to roughly 1750 items.
    localparam int MIX_ITEMS = 510;
    // Feeds of one repeated character in the repeated-pair test.
    localparam int REPEAT_FEEDS = 40;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    // Idling chances in percent, changed by the test tasks between phases.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Request for a long receiver hold-off and the cycles of it still to run.
    bit stall_req = 1'b0;
    int stall_left = 0;

    // Our own copy of the block's state, updated as each item is accepted.
    logic [COUNT_W-1:0] pair_tally [TABLE_SIZE];
    logic [CHAR_W-1:0]  prev_char;
    bit                 have_prev;
    int                 scan_ptr;

    // Fetch results that have been predicted but not yet seen on the output.
    bph_result_t pending_pairs [$];

    int mismatch_count = 0;
    int idle_cycles = 0;
    int feeds_sent = 0;
    int fetches_sent = 0;
    int clears_sent = 0;
    int unused_sent = 0;
    int results_checked = 0;
    int pairs_reported = 0;

    byte_pair_histogram dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // character[7:0]
        .s_axis_tuser  (s_axis_tuser),   // operation[1:0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // first_char[7:0], second_char[15:8],
                                         // pair_count[31:16]
        .m_axis_tuser  (m_axis_tuser)    // found[0]
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Empties the table and forgets the previous character and the scan, as
    // reset and a clear item both do.
    function automatic void wipe_histogram();
        foreach (pair_tally[i])
            pair_tally[i] = '0;
        prev_char = '0;
        have_prev = 1'b0;
        scan_ptr  = 0;
    endfunction

    // Applies one accepted item to our copy of the state. Returns 1 when the
    // item is a fetch, with the result the block must send in res.
    function automatic bit predict_item(input logic [OP_W-1:0] op,
                                        input logic [CHAR_W-1:0] ch,
                                        output bph_result_t res);
        int pos;
        res = '0;
        case (op)
            OP_FEED:
            begin
                // The pair index puts the earlier character in the upper byte,
                // so the scan order is first character major.
                if (have_prev && pair_tally[{prev_char, ch}] != COUNT_TOP)
                    pair_tally[{prev_char, ch}] = pair_tally[{prev_char, ch}] + 1'b1;
                prev_char = ch;
                have_prev = 1'b1;
                return 1'b0;
            end
            OP_CLEAR:
            begin
                wipe_histogram();
                return 1'b0;
            end
            OP_FETCH:
            begin
                // The scan only moves forward: pairs below the scan position
                // that were counted after it passed are never reported.
                pos = scan_ptr;
                while (pos < TABLE_SIZE && pair_tally[pos] == '0)
                    pos++;
                if (pos < TABLE_SIZE)
                begin
                    res.first_char  = pos[15:8];
                    res.second_char = pos[7:0];
                    res.pair_count  = pair_tally[pos];
                    res.found       = 1'b1;
                    scan_ptr = pos + 1;
                end
                else
                    scan_ptr = TABLE_SIZE;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driving the input channel
    // ------------------------------------------------------------------

    // Offers one item at a falling edge, after any random idle cycles, and
    // returns at the rising edge where the block takes it. tvalid stays high
    // afterwards, so the next call or release_bus must follow directly.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch);
        bph_result_t res;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (predict_item(op, ch, res))
            pending_pairs.push_back(res);
        case (op)
            OP_FEED:  feeds_sent++;
            OP_FETCH: fetches_sent++;
            OP_CLEAR: clears_sent++;
            default:  unused_sent++;
        endcase
    endtask

    // Withdraws the sender from the bus at the next falling edge.
    task automatic release_bus();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // The sender pauses until every predicted result has been received.
    task automatic wait_drained();
        release_bus();
        while (pending_pairs.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: receiver readiness and the result checker
    // ------------------------------------------------------------------

    // tready changes only at falling edges. A hold-off request takes
    // precedence over the random idling and is counted down here.
    always @(negedge clk)
    begin
        if (stall_req)
        begin
            stall_left = HOLD_CYCLES;
            stall_req  = 1'b0;
        end
        if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0h, actual %0h", $realtime, name, want, got);
        end
    endtask

    // Every result taken at a rising edge is matched against the oldest
    // prediction, field by field.
    always @(posedge clk)
    begin
        bph_result_t got;
        bph_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tuser, m_axis_tdata};
            if (pending_pairs.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result with none outstanding, expected nothing, actual %h",
                         $realtime, got);
            end
            else
            begin
                want = pending_pairs.pop_front();
                compare_field("first_char", int'(want.first_char), int'(got.first_char));
                compare_field("second_char", int'(want.second_char),
                              int'(got.second_char));
                compare_field("pair_count", int'(want.pair_count), int'(got.pair_count));
                compare_field("found", int'(want.found), int'(got.found));
                results_checked++;
                if (want.found)
                    pairs_reported++;
            end
        end
    end

    // The watchdog counts cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $realtime, idle_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Short strings, the extreme characters, the ignored code, ordering of
    // the report, a feed in the middle of a scan and the exhausted table.
    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // With nothing fed the first fetch finds no pair at all.
        send_item(OP_FETCH, 8'h00);
        // A single byte still makes no pair.
        send_item(OP_FEED, 8'h41);
        send_item(OP_FETCH, 8'hFF);
        // The unused code must change nothing.
        send_item(OP_UNUSED, 8'hA5);
        send_item(OP_CLEAR, 8'h5A);
        // Pairs at both corners of the table, two of them counted twice.
        send_item(OP_FEED, 8'h00);
        send_item(OP_FEED, 8'h00);
        send_item(OP_FEED, 8'hFF);
        send_item(OP_FEED, 8'hFF);
        send_item(OP_FEED, 8'h00);
        send_item(OP_FEED, 8'hFF);
        send_item(OP_FEED, 8'h00);
        send_item(OP_UNUSED, 8'h00);
        send_item(OP_FETCH, 8'h00);
        // These feeds land behind and ahead of the scan position.
        send_item(OP_FEED, 8'h00);
        send_item(OP_FEED, 8'h01);
        send_item(OP_FETCH, 8'h00);
        send_item(OP_FETCH, 8'h00);
        send_item(OP_FETCH, 8'h00);
        send_item(OP_FETCH, 8'h00);
        // The table is exhausted now, and stays so.
        send_item(OP_FETCH, 8'hFF);
        send_item(OP_FETCH, 8'h00);
        wait_drained();
        send_item(OP_CLEAR, 8'hFF);
    endtask

    // One character repeated many times, so that a single counter climbs
    // well above the one other pair that the final feed adds; the rest stays empty.
    task automatic test_repeat_pair();
        int k;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (k = 0; k < REPEAT_FEEDS; k++)
            send_item(OP_FEED, 8'h7E);
        send_item(OP_FEED, 8'h7F);
        send_item(OP_FETCH, 8'h00);
        send_item(OP_FETCH, 8'h00);
        send_item(OP_FETCH, 8'h00);
        wait_drained();
        send_item(OP_CLEAR, 8'h00);
    endtask

    // Random strings in bursts: a run of feeds, then a run of fetches, with
    // the odd unused code mixed in. Most characters come from a small
    // alphabet so that pairs repeat; the rest span the whole byte range.
    task automatic test_random_mix(input int send_pct, input int recv_pct);
        logic [CHAR_W-1:0] alphabet [6];
        int done;
        int run;
        int k;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        foreach (alphabet[i])
            alphabet[i] = CHAR_W'($urandom_range(0, 255));
        done = 0;
        while (done < MIX_ITEMS)
        begin
            run = $urandom_range(1, 20);
            for (k = 0; k < run; k++)
            begin
                if ($urandom_range(0, 99) < 60)
                    send_item(OP_FEED, alphabet[$urandom_range(0, 5)]);
                else
                    send_item(OP_FEED, CHAR_W'($urandom_range(0, 255)));
                if ($urandom_range(0, 99) < 3)
                    send_item(OP_UNUSED, CHAR_W'($urandom_range(0, 255)));
            end
            done += run;
            run = $urandom_range(1, 6);
            for (k = 0; k < run; k++)
                send_item(OP_FETCH, CHAR_W'($urandom_range(0, 255)));
            done += run;
        end
        wait_drained();
        send_item(OP_CLEAR, CHAR_W'($urandom_range(0, 255)));
    endtask

    // The receiver holds off for a long stretch while fetches keep coming,
    // so the output register fills and the block stalls its input; then the
    // sender waits for every result before the table is read out.
    task automatic test_backpressure();
        logic [CHAR_W-1:0] letters [4];
        int k;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        foreach (letters[i])
            letters[i] = CHAR_W'($urandom_range(0, 255));
        for (k = 0; k < 40; k++)
            send_item(OP_FEED, letters[$urandom_range(0, 3)]);
        // We are at a rising edge here, clear of the receiver's falling edge.
        stall_req = 1'b1;
        for (k = 0; k < 24; k++)
        begin
            if (k % 3 == 2)
                send_item(OP_FEED, letters[$urandom_range(0, 3)]);
            else
                send_item(OP_FETCH, CHAR_W'($urandom_range(0, 255)));
        end
        wait_drained();
        for (k = 0; k < 20; k++)
            send_item(OP_FETCH, CHAR_W'($urandom_range(0, 255)));
        wait_drained();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_FEED;
        wipe_histogram();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The block clears its table after reset; the first item simply
        // waits for tready.
        test_directed();
        test_repeat_pair();
        test_random_mix(34, 47);
        test_random_mix(47, 34);
        test_random_mix(0, 0);
        test_backpressure();

        release_bus();
        while (pending_pairs.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d feeds, %0d fetches, %0d clears and %0d unused codes,",
                 feeds_sent, fetches_sent, clears_sent, unused_sent);
        $display("with %0d results checked, %0d of them reporting a pair.",
                 results_checked, pairs_reported);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
